[hw/rtl/arm_alu_with_barrel_shifter_macros.svh]
// ----------------------------------------------------------------------------
// arm_alu_with_barrel_shifter_macros.svh
// assertion macros used by the checker file of the alu block
// ----------------------------------------------------------------------------
`ifndef ARM_ALU_WITH_BARREL_SHIFTER_MACROS_SVH
`define ARM_ALU_WITH_BARREL_SHIFTER_MACROS_SVH

// same-cycle implication, switched off while reset is low
`define ARMALU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("armalu check failed");

// next-cycle implication, switched off while reset is low
`define ARMALU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("armalu check failed");

`endif

[hw/rtl/armalu_pkg.sv]
// ----------------------------------------------------------------------------
// armalu_pkg
// opcodes, shift types and flag positions of the data-processing alu
// ----------------------------------------------------------------------------
`default_nettype none

package armalu_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_alu_op;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    // bit positions in the status flag register
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

endpackage

`default_nettype wire

[hw/rtl/arm_alu_with_barrel_shifter.sv]
// ----------------------------------------------------------------------------
// arm_alu_with_barrel_shifter
// One data-processing operation per item: operand B goes through an
// immediate-amount barrel shifter, then one of sixteen ALU operations
// combines it with operand A; the NZCV flags are updated when flags are set
// or the operation writes no result. The block takes one item per clock
// unless held off; a result is offered once its item has moved from the
// input register into the result register, and an input item is only held
// off while both registers are full and the result is stalled. The rate is
// set by the status flag register, which is written as each item moves into
// the result register, so the carry is ready for the very next item.
`default_nettype none

module arm_alu_with_barrel_shifter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_cmd,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    input  wire logic [1:0]  i_shift_type,
    input  wire logic [4:0]  i_shift_amount,
    input  wire logic        i_set_flags,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_result,
    output logic             o_writes_result,
    output logic             o_flag_n,
    output logic             o_flag_z,
    output logic             o_flag_c,
    output logic             o_flag_v
);

    // input register
    logic                  r_in_valid;
    armalu_pkg::t_alu_op   r_cmd;
    logic [31:0]           r_a;
    logic [31:0]           r_b;
    armalu_pkg::t_shift    r_type;
    logic [4:0]            r_amt;
    logic                  r_set;

    // result register and flags
    logic                  r_out_valid;
    logic [31:0]           r_result;
    logic                  r_writes;
    logic [3:0]            r_flags;
    logic [3:0]            n_flags;

    logic                  adv;
    logic                  c_in;

    logic [32:0]           lsl_w;
    logic [32:0]           lsr_w;
    logic [32:0]           asr_w;
    logic [63:0]           ror_w;
    logic [31:0]           b_sh;
    logic                  sh_c;

    logic [31:0]           add_x;
    logic [31:0]           add_y;
    logic                  add_cin;
    logic [32:0]           sum;
    logic                  add_v;

    logic [31:0]           alu_r;
    logic                  arith;
    logic                  writes;
    logic                  upd;

    assign adv     = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign c_in    = r_flags[armalu_pkg::FLAG_C];

    // barrel shifter, one extra bit on the side that catches the carry
    assign lsl_w = {1'b0, r_b} << r_amt;
    assign lsr_w = {r_b, 1'b0} >> r_amt;
    assign asr_w = 33'($signed({r_b, 1'b0}) >>> r_amt);
    assign ror_w = {r_b, r_b} >> r_amt;

    always_comb begin
        b_sh = r_b;
        sh_c = c_in;
        case (r_type)
            armalu_pkg::SH_LSL: begin
                if (r_amt != 5'd0) begin
                    b_sh = lsl_w[31:0];
                    sh_c = lsl_w[32];
                end
            end
            armalu_pkg::SH_LSR: begin
                if (r_amt == 5'd0) begin
                    b_sh = '0;
                    sh_c = r_b[31];
                end else begin
                    b_sh = lsr_w[32:1];
                    sh_c = lsr_w[0];
                end
            end
            armalu_pkg::SH_ASR: begin
                if (r_amt == 5'd0) begin
                    b_sh = {32{r_b[31]}};
                    sh_c = r_b[31];
                end else begin
                    b_sh = asr_w[32:1];
                    sh_c = asr_w[0];
                end
            end
            default: begin
                if (r_amt == 5'd0) begin
                    // rrx
                    b_sh = {c_in, r_b[31:1]};
                    sh_c = r_b[0];
                end else begin
                    b_sh = ror_w[31:0];
                    sh_c = ror_w[31];
                end
            end
        endcase
    end

    // adder operand selection
    always_comb begin
        add_x   = r_a;
        add_y   = b_sh;
        add_cin = 1'b0;
        unique case (r_cmd) inside
            armalu_pkg::OP_SUB, armalu_pkg::OP_CMP: begin
                add_y   = ~b_sh;
                add_cin = 1'b1;
            end
            armalu_pkg::OP_RSB: begin
                add_x   = b_sh;
                add_y   = ~r_a;
                add_cin = 1'b1;
            end
            armalu_pkg::OP_ADC: begin
                add_cin = c_in;
            end
            armalu_pkg::OP_SBC: begin
                add_y   = ~b_sh;
                add_cin = c_in;
            end
            armalu_pkg::OP_RSC: begin
                add_x   = b_sh;
                add_y   = ~r_a;
                add_cin = c_in;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_v = (add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]);

    always_comb begin
        alu_r  = sum[31:0];
        arith  = 1'b0;
        writes = 1'b1;
        unique case (r_cmd) inside
            armalu_pkg::OP_AND: alu_r = r_a & b_sh;
            armalu_pkg::OP_EOR: alu_r = r_a ^ b_sh;
            armalu_pkg::OP_TST: begin
                alu_r  = r_a & b_sh;
                writes = 1'b0;
            end
            armalu_pkg::OP_TEQ: begin
                alu_r  = r_a ^ b_sh;
                writes = 1'b0;
            end
            armalu_pkg::OP_CMP, armalu_pkg::OP_CMN: begin
                arith  = 1'b1;
                writes = 1'b0;
            end
            armalu_pkg::OP_ORR: alu_r = r_a | b_sh;
            armalu_pkg::OP_MOV: alu_r = b_sh;
            armalu_pkg::OP_BIC: alu_r = r_a & ~b_sh;
            armalu_pkg::OP_MVN: alu_r = ~b_sh;
            default:            arith = 1'b1;
        endcase
    end

    assign upd = r_set || !writes;

    always_comb begin
        n_flags = r_flags;
        if (upd) begin
            n_flags[armalu_pkg::FLAG_N] = alu_r[31];
            n_flags[armalu_pkg::FLAG_Z] = (alu_r == 32'd0);
            n_flags[armalu_pkg::FLAG_C] = arith ? sum[32] : sh_c;
            n_flags[armalu_pkg::FLAG_V] = arith ? add_v : r_flags[armalu_pkg::FLAG_V];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd  <= armalu_pkg::t_alu_op'(i_cmd);
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_type <= armalu_pkg::t_shift'(i_shift_type);
            r_amt  <= i_shift_amount;
            r_set  <= i_set_flags;
        end
        if (adv) begin
            r_result <= alu_r;
            r_writes <= writes;
        end
    end

    // flags only change when a new item enters the result register
    assign o_valid         = r_out_valid;
    assign o_result        = r_result;
    assign o_writes_result = r_writes;
    assign o_flag_n        = r_flags[armalu_pkg::FLAG_N];
    assign o_flag_z        = r_flags[armalu_pkg::FLAG_Z];
    assign o_flag_c        = r_flags[armalu_pkg::FLAG_C];
    assign o_flag_v        = r_flags[armalu_pkg::FLAG_V];

endmodule

`default_nettype wire

[hw/rtl/armalu_checker.sv]
// ----------------------------------------------------------------------------
// armalu_checker
// port-level checks on the data-processing alu, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "arm_alu_with_barrel_shifter_macros.svh"

module armalu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_result,
    input wire logic        o_writes_result,
    input wire logic        o_flag_n,
    input wire logic        o_flag_z,
    input wire logic        o_flag_c,
    input wire logic        o_flag_v
);

    logic [3:0] flags_now;
    logic       nz_match;

    assign flags_now = {o_flag_n, o_flag_z, o_flag_c, o_flag_v};
    assign nz_match  = (o_flag_z == (o_result == 32'd0)) && (o_flag_n == o_result[31]);

    // a held result keeps its value
    `ARMALU_ASSERT_NXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result))

    // held flags do not move under a stall
    `ARMALU_ASSERT_NXT(a_flags_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(flags_now))

    // upstream only waits when the result register is full and held
    `ARMALU_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // compare and test always set n and z from their value
    `ARMALU_ASSERT_IMP(a_cmp_flags, i_clk, i_rst_n, o_valid && !o_writes_result, nz_match)

endmodule

bind arm_alu_with_barrel_shifter armalu_checker u_armalu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_result        (o_result),
    .o_writes_result (o_writes_result),
    .o_flag_n        (o_flag_n),
    .o_flag_z        (o_flag_z),
    .o_flag_c        (o_flag_c),
    .o_flag_v        (o_flag_v)
);

`default_nettype wire

[tb/sv/tb_arm_alu_with_barrel_shifter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_alu_with_barrel_shifter
// Drives data-processing operations through the alu with random gaps on both
// handshakes. It starts with a short table of edge cases, then sends random
// operations. Each result is compared with its typed table row, if any, or
// with an in-order model of the shifter, the alu and the nzcv flags.
// ----------------------------------------------------------------------------

module tb_arm_alu_with_barrel_shifter;

    localparam int DIR_N     = 25;
    localparam int RAND_N    = 1700;
    localparam int CYC_LIMIT = 200000;
    localparam int LONG_HOLD = 150;

    typedef struct packed {
        armalu_pkg::t_alu_op op;
        logic [31:0]         a;
        logic [31:0]         b;
        armalu_pkg::t_shift  sh;
        logic [4:0]          amt;
        logic                sf;
    } t_alu_item;

    typedef struct packed {
        logic [31:0] res;
        logic        wr;
        logic [3:0]  nzcv;
    } t_alu_res;

    typedef struct packed {
        t_alu_item item;
        logic      typed;
        t_alu_res  want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_cmd = armalu_pkg::OP_AND;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic [1:0]  i_shift_type = armalu_pkg::SH_LSL;
    logic [4:0]  i_shift_amount = '0;
    logic        i_set_flags = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result;
    logic        o_writes_result;
    logic        o_flag_n;
    logic        o_flag_z;
    logic        o_flag_c;
    logic        o_flag_v;

    t_alu_res  pending_q[$];
    t_alu_res  oldest;
    logic [3:0] model_flags = 4'b0000;
    int        n_sent = 0;
    int        n_got = 0;
    int        n_err = 0;
    int        cyc = 0;
    t_dir_row  dir_tab[DIR_N];

    arm_alu_with_barrel_shifter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_shift_type   (i_shift_type),
        .i_shift_amount (i_shift_amount),
        .i_set_flags    (i_set_flags),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (o_result),
        .o_writes_result(o_writes_result),
        .o_flag_n       (o_flag_n),
        .o_flag_z       (o_flag_z),
        .o_flag_c       (o_flag_c),
        .o_flag_v       (o_flag_v)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shifter, alu and flag update for one operation, in acceptance order
    function automatic t_alu_res alu_predict(t_alu_item it);
        t_alu_res    r;
        logic [31:0] bs;
        logic [31:0] x;
        logic [31:0] y;
        logic [32:0] sum;
        logic        sc;
        logic        cin;
        logic        ci;
        logic        arith;
        int unsigned sa;
        cin   = model_flags[armalu_pkg::FLAG_C];
        sa    = 32'(it.amt);
        x     = '0;
        y     = '0;
        ci    = 1'b0;
        arith = 1'b0;
        case (it.sh)
            armalu_pkg::SH_LSL: begin
                if (sa == 0) begin
                    bs = it.b;
                    sc = cin;
                end else begin
                    bs = it.b << sa;
                    sc = it.b[32 - sa];
                end
            end
            armalu_pkg::SH_LSR: begin
                if (sa == 0) begin
                    bs = '0;
                    sc = it.b[31];
                end else begin
                    bs = it.b >> sa;
                    sc = it.b[sa - 1];
                end
            end
            armalu_pkg::SH_ASR: begin
                if (sa == 0) begin
                    bs = {32{it.b[31]}};
                    sc = it.b[31];
                end else begin
                    bs = $unsigned($signed(it.b) >>> sa);
                    sc = it.b[sa - 1];
                end
            end
            default: begin
                // amount zero is rrx through the held carry
                if (sa == 0) begin
                    bs = {cin, it.b[31:1]};
                    sc = it.b[0];
                end else begin
                    bs = (it.b >> sa) | (it.b << (32 - sa));
                    sc = it.b[sa - 1];
                end
            end
        endcase
        case (it.op)
            armalu_pkg::OP_SUB, armalu_pkg::OP_CMP: begin
                x = it.a; y = ~bs; ci = 1'b1; arith = 1'b1;
            end
            armalu_pkg::OP_RSB: begin
                x = bs; y = ~it.a; ci = 1'b1; arith = 1'b1;
            end
            armalu_pkg::OP_ADD, armalu_pkg::OP_CMN: begin
                x = it.a; y = bs; ci = 1'b0; arith = 1'b1;
            end
            armalu_pkg::OP_ADC: begin
                x = it.a; y = bs; ci = cin; arith = 1'b1;
            end
            armalu_pkg::OP_SBC: begin
                x = it.a; y = ~bs; ci = cin; arith = 1'b1;
            end
            armalu_pkg::OP_RSC: begin
                x = bs; y = ~it.a; ci = cin; arith = 1'b1;
            end
            default: ;
        endcase
        sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
        case (it.op)
            armalu_pkg::OP_AND, armalu_pkg::OP_TST: r.res = it.a & bs;
            armalu_pkg::OP_EOR, armalu_pkg::OP_TEQ: r.res = it.a ^ bs;
            armalu_pkg::OP_ORR:                     r.res = it.a | bs;
            armalu_pkg::OP_MOV:                     r.res = bs;
            armalu_pkg::OP_BIC:                     r.res = it.a & ~bs;
            armalu_pkg::OP_MVN:                     r.res = ~bs;
            default:                                r.res = sum[31:0];
        endcase
        r.wr = !(it.op inside {armalu_pkg::OP_TST, armalu_pkg::OP_TEQ,
                               armalu_pkg::OP_CMP, armalu_pkg::OP_CMN});
        if (it.sf || !r.wr) begin
            model_flags[armalu_pkg::FLAG_N] = r.res[31];
            model_flags[armalu_pkg::FLAG_Z] = (r.res == 32'd0);
            if (arith) begin
                model_flags[armalu_pkg::FLAG_C] = sum[32];
                model_flags[armalu_pkg::FLAG_V] = (x[31] ^ r.res[31]) & (y[31] ^ r.res[31]);
            end else begin
                model_flags[armalu_pkg::FLAG_C] = sc;
            end
        end
        r.nzcv = model_flags;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom_range(0, 15);
            5:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_err++;
        if (n_err <= 100)
            $display("mismatch %s at result %0d: got %h want %h", what, n_got, got, want);
    endtask

    task automatic send_item(t_alu_item it, logic typed, t_alu_res typed_res);
        int       gap;
        t_alu_res want;
        gap = (((n_sent / 200) % 4) == 3) ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_cmd          <= it.op;
        i_operand_a    <= it.a;
        i_operand_b    <= it.b;
        i_shift_type   <= it.sh;
        i_shift_amount <= it.amt;
        i_set_flags    <= it.sf;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = alu_predict(it);
        if (typed) want = typed_res;
        pending_q.push_back(want);
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: random hold-off per item, calm stretches, two long holds
    initial begin : receiver
        int  wait_n;
        logic hold1_done;
        logic hold2_done;
        hold1_done = 1'b0;
        hold2_done = 1'b0;
        forever begin
            wait_n = (((n_got / 170) % 4) == 1) ? 0 : $urandom_range(0, 6);
            if (!hold1_done && n_got >= 300) begin
                wait_n = LONG_HOLD;
                hold1_done = 1'b1;
            end else if (!hold2_done && n_got >= 1300) begin
                wait_n = LONG_HOLD;
                hold2_done = 1'b1;
            end
            repeat (wait_n) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!(i_rst_n && o_valid)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYC_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected item", o_result, 32'd0);
            end else begin
                oldest = pending_q.pop_front();
                if (o_result !== oldest.res)
                    report_mismatch("result", o_result, oldest.res);
                if (o_writes_result !== oldest.wr)
                    report_mismatch("writes_result", 32'(o_writes_result), 32'(oldest.wr));
                if (o_flag_n !== oldest.nzcv[armalu_pkg::FLAG_N])
                    report_mismatch("flag_n", 32'(o_flag_n),
                                    32'(oldest.nzcv[armalu_pkg::FLAG_N]));
                if (o_flag_z !== oldest.nzcv[armalu_pkg::FLAG_Z])
                    report_mismatch("flag_z", 32'(o_flag_z),
                                    32'(oldest.nzcv[armalu_pkg::FLAG_Z]));
                if (o_flag_c !== oldest.nzcv[armalu_pkg::FLAG_C])
                    report_mismatch("flag_c", 32'(o_flag_c),
                                    32'(oldest.nzcv[armalu_pkg::FLAG_C]));
                if (o_flag_v !== oldest.nzcv[armalu_pkg::FLAG_V])
                    report_mismatch("flag_v", 32'(o_flag_v),
                                    32'(oldest.nzcv[armalu_pkg::FLAG_V]));
            end
            n_got++;
        end
    end

    initial begin : stimulus
        t_alu_item it;
        t_alu_res  none;
        int        pick;
        none = '0;
        // typed rows follow the flags from reset; the rest go to the predictor
        dir_tab = '{
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b0}, 1'b1,
              '{32'h0, 1'b1, 4'b0000}},
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b1}, 1'b1,
              '{32'h0, 1'b1, 4'b0100}},
            '{'{armalu_pkg::OP_CMP, 32'h0, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b0}, 1'b1,
              '{32'h0, 1'b0, 4'b0110}},
            '{'{armalu_pkg::OP_MVN, 32'h0, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b1}, 1'b1,
              '{32'hffff_ffff, 1'b1, 4'b1010}},
            '{'{armalu_pkg::OP_ADD, 32'h7fff_ffff, 32'h1, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b1, '{32'h8000_0000, 1'b1, 4'b1001}},
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h8000_0000, armalu_pkg::SH_LSR, 5'd0, 1'b1},
              1'b1, '{32'h0, 1'b1, 4'b0111}},
            '{'{armalu_pkg::OP_ADD, 32'hffff_ffff, 32'h1, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b1, '{32'h0, 1'b1, 4'b0110}},
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h3, armalu_pkg::SH_ROR, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h2, armalu_pkg::SH_ROR, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h8000_0001, armalu_pkg::SH_ASR, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_MOV, 32'h0, 32'h7fff_ffff, armalu_pkg::SH_ASR, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_ORR, 32'h0, 32'hffff_ffff, armalu_pkg::SH_LSL, 5'd31, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_EOR, 32'hffff_ffff, 32'h8000_0000, armalu_pkg::SH_LSR,
                5'd31, 1'b1}, 1'b0, none},
            '{'{armalu_pkg::OP_AND, 32'hffff_ffff, 32'hf0f0_f0f0, armalu_pkg::SH_ROR,
                5'd4, 1'b1}, 1'b0, none},
            '{'{armalu_pkg::OP_BIC, 32'hffff_ffff, 32'hffff_ffff, armalu_pkg::SH_LSL,
                5'd0, 1'b1}, 1'b0, none},
            '{'{armalu_pkg::OP_SUB, 32'h0, 32'h1, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_RSB, 32'h1, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_ADC, 32'hffff_ffff, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_SBC, 32'h8000_0000, 32'h0, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_RSC, 32'h0, 32'h8000_0000, armalu_pkg::SH_LSL, 5'd0, 1'b1},
              1'b0, none},
            '{'{armalu_pkg::OP_TST, 32'h8000_0000, 32'h8000_0000, armalu_pkg::SH_LSL,
                5'd0, 1'b0}, 1'b0, none},
            '{'{armalu_pkg::OP_TEQ, 32'hffff_ffff, 32'hffff_ffff, armalu_pkg::SH_LSL,
                5'd0, 1'b0}, 1'b0, none},
            '{'{armalu_pkg::OP_CMN, 32'h8000_0000, 32'h8000_0000, armalu_pkg::SH_LSL,
                5'd0, 1'b0}, 1'b0, none},
            '{'{armalu_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, armalu_pkg::SH_ASR,
                5'd31, 1'b0}, 1'b0, none},
            '{'{armalu_pkg::OP_MVN, 32'hffff_ffff, 32'h0, armalu_pkg::SH_LSR, 5'd1, 1'b0},
              1'b0, none}
        };
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < DIR_N; k++)
            send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
        wait_drained();
        for (int k = 0; k < RAND_N; k++) begin
            if (k == RAND_N / 2) wait_drained();
            it.op = armalu_pkg::t_alu_op'($urandom_range(0, 15));
            it.a  = rand_word();
            it.b  = rand_word();
            it.sh = armalu_pkg::t_shift'($urandom_range(0, 3));
            pick  = $urandom_range(0, 3);
            // amount zero is special for every shift type, so it comes often
            it.amt = (pick == 0) ? 5'd0 : 5'($urandom_range(0, 31));
            it.sf  = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, none);
        end
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_q.size() != 0)
            report_mismatch("items left over", 32'(pending_q.size()), 32'd0);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
